FILE: hdl/emmc_init_sequencer_assert.svh
// Assertion macros shared by the eMMC init sequencer modules.
`ifndef EMMC_INIT_SEQUENCER_ASSERT_SVH
`define EMMC_INIT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define EIS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define EIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/eis_pkg.sv
// Package: codes, constants and the queued item type of the eMMC init sequencer.
package eis_pkg;

  localparam int EIS_QUEUE_DEPTH = 4;
  localparam int EXT_CSD_BYTES   = 512;

  // Request type codes
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_RESP  = 3'd1;
  localparam logic [2:0] REQ_DATA  = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_PAUSE = 3'd4;

  // Action codes
  localparam logic [1:0] ACT_ISSUE = 2'd1;
  localparam logic [1:0] ACT_PAUSE = 2'd2;
  localparam logic [1:0] ACT_DONE  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_IO      = 3'd3;
  localparam logic [2:0] ST_UNSUP   = 3'd4;
  localparam logic [2:0] ST_CMDFAIL = 3'd5;

  // Response kinds
  localparam logic [2:0] RK_NONE = 3'd0;
  localparam logic [2:0] RK_R1   = 3'd1;
  localparam logic [2:0] RK_R1B  = 3'd2;
  localparam logic [2:0] RK_R2   = 3'd3;
  localparam logic [2:0] RK_R3   = 3'd4;

  // Command numbers
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_OP   = 6'd1;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SET_RCA   = 6'd3;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_EXT_CSD   = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
  localparam logic [5:0] CMD_STATUS    = 6'd13;

  // Arguments and masks
  localparam logic [31:0] R1_ALLOWED     = 32'h0206_bf7f;
  localparam logic [31:0] CMD1_ARG       = 32'h40ff_8000;
  localparam logic [31:0] OCR_BUSY_MASK  = 32'h8000_0000;
  localparam logic [31:0] OCR_MODE_MASK  = 32'h6000_0000;
  localparam logic [31:0] OCR_MODE_SECT  = 32'h4000_0000;
  localparam logic [31:0] OCR_VOLT_MASK  = 32'h00ff_8000;
  localparam logic [31:0] RCA_ARG        = 32'h0001_0000;
  localparam logic [31:0] STATE_MASK     = 32'h0000_1f00;
  localparam logic [31:0] STATE_TRAN_RDY = 32'h0000_0900;

  // EXT_CSD byte positions
  localparam logic [8:0] XCSD_SEC_SIZE  = 9'd61;
  localparam logic [8:0] XCSD_PART_CFG  = 9'd179;
  localparam logic [8:0] XCSD_BUS_WIDTH = 9'd183;
  localparam logic [8:0] XCSD_HS_TIMING = 9'd185;
  localparam logic [8:0] XCSD_REV       = 9'd192;
  localparam logic [8:0] XCSD_SEC_CNT0  = 9'd212;
  localparam logic [8:0] XCSD_SEC_CNT1  = 9'd213;
  localparam logic [8:0] XCSD_SEC_CNT2  = 9'd214;
  localparam logic [8:0] XCSD_SEC_CNT3  = 9'd215;
  localparam logic [7:0] XCSD_MIN_REV   = 8'd2;

  typedef enum logic [2:0] {
    IK_START, IK_RESP, IK_DATA, IK_TICK, IK_PAUSE
  } item_kind_t;

  typedef enum logic [3:0] {
    CAP_NONE, CAP_SEC_SIZE, CAP_PART, CAP_BUS_WIDTH, CAP_TIMING, CAP_REV,
    CAP_SEC0, CAP_SEC1, CAP_SEC2, CAP_SEC3
  } cap_sel_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    item_kind_t  kind;
    logic        cmd_failed;
    logic        r1_err;
    logic        ocr_busy;
    logic        ocr_bad;
    logic        tran_bad;
    logic [31:0] resp_word;
    cap_sel_t    cap_sel;
    logic [7:0]  data_byte;
    logic [15:0] tick_us;
  } eis_item_t;

endpackage

FILE: hdl/eis_req_if.sv
// Request channel interface of the eMMC init sequencer.
interface eis_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic        cmd_failed;
  logic [31:0] resp_word;
  logic [8:0]  data_index;
  logic [7:0]  data_byte;
  logic [15:0] tick_us;

  modport source (output valid, req_type, cmd_failed, resp_word, data_index, data_byte,
                  tick_us, input ready);
  modport sink (input valid, req_type, cmd_failed, resp_word, data_index, data_byte,
                tick_us, output ready);
endinterface

FILE: hdl/eis_rsp_if.sv
// Result channel interface of the eMMC init sequencer.
interface eis_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic [2:0]  resp_kind;
  logic        expects_data;
  logic [31:0] remaining_us;
  logic [2:0]  status;
  logic        card_ready;
  logic [31:0] ocr_value;
  logic [31:0] sector_count;

  modport source (output valid, action, cmd_index, cmd_arg, resp_kind, expects_data,
                  remaining_us, status, card_ready, ocr_value, sector_count, input ready);
  modport sink (input valid, action, cmd_index, cmd_arg, resp_kind, expects_data,
                remaining_us, status, card_ready, ocr_value, sector_count, output ready);
endinterface

FILE: hdl/eis_cfg_if.sv
// Configuration write channel interface of the eMMC init sequencer.
interface eis_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] timeout_budget_us;

  modport source (output valid, timeout_budget_us, input ready);
  modport sink (input valid, timeout_budget_us, output ready);
endinterface

FILE: hdl/eis_front.sv
// Front end: accept requests, classify them and drop items that cannot matter.
module eis_front
  import eis_pkg::*;
(
  eis_req_if.sink   req,
  input  logic      can_push,
  output logic      push,
  output eis_item_t item
);

  logic keep;

  assign req.ready = can_push;

  always_comb begin
    item            = '0;
    item.cmd_failed = req.cmd_failed;
    item.resp_word  = req.resp_word;
    item.data_byte  = req.data_byte;
    item.tick_us    = req.tick_us;
    item.r1_err     = (req.resp_word & ~R1_ALLOWED) != 32'd0;
    item.ocr_busy   = (req.resp_word & OCR_BUSY_MASK) == 32'd0;
    item.ocr_bad    = ((req.resp_word & OCR_MODE_MASK) != OCR_MODE_SECT) ||
                      ((req.resp_word & OCR_VOLT_MASK) == 32'd0);
    item.tran_bad   = (req.resp_word & STATE_MASK) != STATE_TRAN_RDY;

    unique case (req.data_index)
      XCSD_SEC_SIZE:  item.cap_sel = CAP_SEC_SIZE;
      XCSD_PART_CFG:  item.cap_sel = CAP_PART;
      XCSD_BUS_WIDTH: item.cap_sel = CAP_BUS_WIDTH;
      XCSD_HS_TIMING: item.cap_sel = CAP_TIMING;
      XCSD_REV:       item.cap_sel = CAP_REV;
      XCSD_SEC_CNT0:  item.cap_sel = CAP_SEC0;
      XCSD_SEC_CNT1:  item.cap_sel = CAP_SEC1;
      XCSD_SEC_CNT2:  item.cap_sel = CAP_SEC2;
      XCSD_SEC_CNT3:  item.cap_sel = CAP_SEC3;
      default:        item.cap_sel = CAP_NONE;
    endcase

    // Bytes past the block or at positions nobody reads never reach the back.
    if ({1'b0, req.data_index} >= 10'(EXT_CSD_BYTES)) begin
      item.cap_sel = CAP_NONE;
    end

    unique case (req.req_type)
      REQ_START: begin
        item.kind = IK_START;
        keep      = 1'b1;
      end
      REQ_RESP: begin
        item.kind = IK_RESP;
        keep      = 1'b1;
      end
      REQ_DATA: begin
        item.kind = IK_DATA;
        keep      = item.cap_sel != CAP_NONE;
      end
      REQ_TICK: begin
        item.kind = IK_TICK;
        keep      = 1'b1;
      end
      REQ_PAUSE: begin
        item.kind = IK_PAUSE;
        keep      = 1'b1;
      end
      default: begin
        item.kind = IK_TICK;
        keep      = 1'b0;
      end
    endcase
  end

  assign push = req.valid && can_push && keep;

endmodule

FILE: hdl/eis_queue.sv
// Short queue of classified items between front and back.
`include "emmc_init_sequencer_assert.svh"
module eis_queue
  import eis_pkg::*;
#(
  parameter int DEPTH = EIS_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  eis_item_t push_item,
  output logic      can_push,
  input  logic      pop,
  output logic      head_valid,
  output eis_item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  eis_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign can_push   = count != CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `EIS_ASSERT_IMPL(a_pop_nonempty, pop, count != '0, "queue popped while empty")
  `EIS_ASSERT_NEXT(a_cnt_up, push && !pop, count == CNT_W'($past(count) + 1'b1), "count did not rise")
  `EIS_ASSERT_NEXT(a_cnt_dn, pop && !push, count == CNT_W'($past(count) - 1'b1), "count did not fall")

endmodule

FILE: hdl/eis_back.sv
// Back end: sequencer state, time budget, EXT_CSD capture and the result register.
`include "emmc_init_sequencer_assert.svh"
module eis_back
  import eis_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  eis_cfg_if.sink   cfg,
  eis_rsp_if.source rsp,
  input  logic      head_valid,
  input  eis_item_t head,
  output logic      pop
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD0, PH_PAUSE0, PH_CMD1, PH_PAUSE1, PH_CMD2, PH_CMD3,
    PH_CMD9, PH_CMD7, PH_CMD8, PH_CMD13
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] budget;
  logic [31:0] elapsed, elapsed_next;
  logic [31:0] ocr, ocr_next;
  logic [7:0]  ext_rev, ext_rev_next;
  logic [2:0]  ext_part, ext_part_next;
  logic [7:0]  ext_bus, ext_bus_next;
  logic [7:0]  ext_timing, ext_timing_next;
  logic [7:0]  ext_sec_size, ext_sec_size_next;
  logic [31:0] sectors, sectors_next;
  logic        ready_flag, ready_flag_next;
  logic [5:0]  last_cmd, last_cmd_next;

  logic        out_valid;
  logic [1:0]  out_action;
  logic [31:0] out_arg;
  logic [2:0]  out_kind;
  logic        out_data;
  logic [31:0] out_remain;
  logic [2:0]  out_status;

  // Result of the item being popped
  logic        res_en;
  logic [1:0]  res_action;
  logic [31:0] res_arg;
  logic [2:0]  res_kind;
  logic        res_data;
  logic [31:0] res_remain;
  logic [2:0]  res_status;

  // Pending issue or finish requested by the decode
  logic        iss_en;
  logic [5:0]  iss_cmd;
  logic [31:0] iss_arg;
  logic [2:0]  iss_kind;
  logic        iss_data;
  phase_t      iss_phase;
  logic        fin_en;
  logic [2:0]  fin_status;

  logic        over;
  logic        r1_phase;
  logic [32:0] tick_sum;

  assign cfg.ready = 1'b1;
  assign pop       = head_valid && (!out_valid || rsp.ready);
  assign over      = elapsed >= budget;
  assign r1_phase  = (phase == PH_CMD3) || (phase == PH_CMD8) || (phase == PH_CMD13) ||
                     (phase == PH_CMD7);
  assign tick_sum  = {1'b0, elapsed} + {17'd0, head.tick_us};

  always_comb begin
    phase_next        = phase;
    elapsed_next      = elapsed;
    ocr_next          = ocr;
    ext_rev_next      = ext_rev;
    ext_part_next     = ext_part;
    ext_bus_next      = ext_bus;
    ext_timing_next   = ext_timing;
    ext_sec_size_next = ext_sec_size;
    sectors_next      = sectors;
    ready_flag_next   = ready_flag;
    last_cmd_next     = last_cmd;
    res_en            = 1'b0;
    res_action        = ACT_DONE;
    res_arg           = '0;
    res_kind          = RK_NONE;
    res_data          = 1'b0;
    res_remain        = '0;
    res_status        = ST_OK;
    iss_en            = 1'b0;
    iss_cmd           = CMD_GO_IDLE;
    iss_arg           = '0;
    iss_kind          = RK_NONE;
    iss_data          = 1'b0;
    iss_phase         = PH_IDLE;
    fin_en            = 1'b0;
    fin_status        = ST_OK;

    unique case (head.kind)
      IK_START: begin
        elapsed_next      = '0;
        ocr_next          = '0;
        ext_rev_next      = '0;
        ext_part_next     = '0;
        ext_bus_next      = '0;
        ext_timing_next   = '0;
        ext_sec_size_next = '0;
        sectors_next      = '0;
        ready_flag_next   = 1'b0;
        last_cmd_next     = CMD_GO_IDLE;
        res_en            = 1'b1;
        if (budget == 32'd0) begin
          phase_next = PH_IDLE;
          res_status = ST_INVALID;
        end else begin
          // Elapsed time was just cleared, so the budget cannot be spent yet.
          phase_next = PH_CMD0;
          res_action = ACT_ISSUE;
          res_remain = budget;
        end
      end
      IK_TICK: begin
        elapsed_next = tick_sum[32] ? '1 : tick_sum[31:0];
      end
      IK_DATA: begin
        if (phase == PH_CMD8) begin
          case (head.cap_sel)
            CAP_SEC_SIZE:  ext_sec_size_next = head.data_byte;
            CAP_PART:      ext_part_next     = head.data_byte[2:0];
            CAP_BUS_WIDTH: ext_bus_next      = head.data_byte;
            CAP_TIMING:    ext_timing_next   = head.data_byte;
            CAP_REV:       ext_rev_next      = head.data_byte;
            CAP_SEC0:      sectors_next[7:0]   = head.data_byte;
            CAP_SEC1:      sectors_next[15:8]  = head.data_byte;
            CAP_SEC2:      sectors_next[23:16] = head.data_byte;
            CAP_SEC3:      sectors_next[31:24] = head.data_byte;
            default:       ;
          endcase
        end
      end
      IK_PAUSE: begin
        if (phase == PH_PAUSE0 || phase == PH_PAUSE1) begin
          iss_en    = 1'b1;
          iss_cmd   = CMD_SEND_OP;
          iss_arg   = CMD1_ARG;
          iss_kind  = RK_R3;
          iss_phase = PH_CMD1;
        end
      end
      IK_RESP: begin
        if (phase != PH_IDLE && phase != PH_PAUSE0 && phase != PH_PAUSE1) begin
          if (over) begin
            fin_en     = 1'b1;
            fin_status = ST_TIMEOUT;
          end else if (head.cmd_failed) begin
            fin_en     = 1'b1;
            fin_status = ST_CMDFAIL;
          end else if (r1_phase && head.r1_err) begin
            fin_en     = 1'b1;
            fin_status = ST_IO;
          end else begin
            unique case (phase)
              PH_CMD0: begin
                phase_next = PH_PAUSE0;
                res_en     = 1'b1;
                res_action = ACT_PAUSE;
              end
              PH_CMD1: begin
                ocr_next = head.resp_word;
                if (head.ocr_busy) begin
                  phase_next = PH_PAUSE1;
                  res_en     = 1'b1;
                  res_action = ACT_PAUSE;
                end else if (head.ocr_bad) begin
                  fin_en     = 1'b1;
                  fin_status = ST_UNSUP;
                end else begin
                  iss_en    = 1'b1;
                  iss_cmd   = CMD_ALL_CID;
                  iss_kind  = RK_R2;
                  iss_phase = PH_CMD2;
                end
              end
              PH_CMD2: begin
                iss_en    = 1'b1;
                iss_cmd   = CMD_SET_RCA;
                iss_arg   = RCA_ARG;
                iss_kind  = RK_R1;
                iss_phase = PH_CMD3;
              end
              PH_CMD3: begin
                iss_en    = 1'b1;
                iss_cmd   = CMD_SEND_CSD;
                iss_arg   = RCA_ARG;
                iss_kind  = RK_R2;
                iss_phase = PH_CMD9;
              end
              PH_CMD9: begin
                iss_en    = 1'b1;
                iss_cmd   = CMD_SELECT;
                iss_arg   = RCA_ARG;
                iss_kind  = RK_R1B;
                iss_phase = PH_CMD7;
              end
              PH_CMD7: begin
                iss_en    = 1'b1;
                iss_cmd   = CMD_EXT_CSD;
                iss_kind  = RK_R1;
                iss_data  = 1'b1;
                iss_phase = PH_CMD8;
              end
              PH_CMD8: begin
                // Check the captured EXT_CSD fields against what the host supports.
                if (ext_rev < XCSD_MIN_REV || ext_part != 3'd0 || ext_bus != 8'd0 ||
                    ext_timing != 8'd0 || ext_sec_size != 8'd0 || sectors == 32'd0) begin
                  fin_en     = 1'b1;
                  fin_status = ST_UNSUP;
                end else begin
                  iss_en    = 1'b1;
                  iss_cmd   = CMD_STATUS;
                  iss_arg   = RCA_ARG;
                  iss_kind  = RK_R1;
                  iss_phase = PH_CMD13;
                end
              end
              PH_CMD13: begin
                fin_en = 1'b1;
                if (head.tran_bad) begin
                  fin_status = ST_IO;
                end else begin
                  ready_flag_next = 1'b1;
                  fin_status      = ST_OK;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase

    // Issue: record the command, then check the budget before sending it.
    if (iss_en) begin
      last_cmd_next = iss_cmd;
      if (over) begin
        fin_en     = 1'b1;
        fin_status = ST_TIMEOUT;
      end else begin
        phase_next = iss_phase;
        res_en     = 1'b1;
        res_action = ACT_ISSUE;
        res_arg    = iss_arg;
        res_kind   = iss_kind;
        res_data   = iss_data;
        res_remain = budget - elapsed;
      end
    end

    if (fin_en) begin
      phase_next = PH_IDLE;
      res_en     = 1'b1;
      res_action = ACT_DONE;
      res_status = fin_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      budget       <= '0;
      elapsed      <= '0;
      ocr          <= '0;
      ext_rev      <= '0;
      ext_part     <= '0;
      ext_bus      <= '0;
      ext_timing   <= '0;
      ext_sec_size <= '0;
      sectors      <= '0;
      ready_flag   <= 1'b0;
      last_cmd     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        budget <= cfg.timeout_budget_us;
      end
      if (pop) begin
        phase        <= phase_next;
        elapsed      <= elapsed_next;
        ocr          <= ocr_next;
        ext_rev      <= ext_rev_next;
        ext_part     <= ext_part_next;
        ext_bus      <= ext_bus_next;
        ext_timing   <= ext_timing_next;
        ext_sec_size <= ext_sec_size_next;
        sectors      <= sectors_next;
        ready_flag   <= ready_flag_next;
        last_cmd     <= last_cmd_next;
      end
      if (pop && res_en) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop && res_en) begin
      out_action            <= res_action;
      out_arg               <= res_arg;
      out_kind              <= res_kind;
      out_data              <= res_data;
      out_remain            <= res_remain;
      out_status            <= res_status;
      rsp.cmd_index         <= last_cmd_next;
      rsp.card_ready        <= ready_flag_next;
      rsp.ocr_value         <= ocr_next;
      rsp.sector_count      <= sectors_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.action       = out_action;
  assign rsp.cmd_arg      = out_arg;
  assign rsp.resp_kind    = out_kind;
  assign rsp.expects_data = out_data;
  assign rsp.remaining_us = out_remain;
  assign rsp.status       = out_status;

  `EIS_ASSERT_IMPL(a_ready_ok, out_valid && rsp.card_ready,
                   out_action == ACT_DONE && out_status == ST_OK, "card ready without clean finish")
  `EIS_ASSERT_IMPL(a_issue_only, out_valid && out_action != ACT_ISSUE,
                   out_arg == 32'd0 && out_remain == 32'd0 && !out_data,
                   "command fields set on a non-issue result")
  `EIS_ASSERT_NEXT(a_time_mono, pop && head.kind != IK_START,
                   elapsed >= $past(elapsed), "elapsed time went backward")

endmodule

FILE: hdl/emmc_init_sequencer.sv
// Top level of the eMMC card initialization sequencer.
//
// Usage: write the microsecond budget on cfg (always ready) while the block
// is idle, then send a start item on req. Each transfer on rsp tells the host
// to issue a command (cmd_index, cmd_arg, resp_kind, expects_data,
// remaining_us), to pause, or that bring-up finished with a status. The host
// answers with response, data byte, tick and pause-done items on req.
// Path: an item transferred on req is written into the item queue; when the
// back end pops it, its result is registered in the result register, and it
// transfers on rsp while rsp.ready is high.
// Throughput: one item per cycle while rsp does not hold a result off.
// Ticks, EXT_CSD bytes and out-of-phase items produce no result but still
// take a back end slot; unused bytes and unknown types drop at the front.
// Stall: while rsp is held off, the front keeps taking items into the queue
// until it fills, then drops req.ready.
// Reset: clears the queue, the result register, the budget and all captured
// card data; the sequencer waits for a start item.
module emmc_init_sequencer
  import eis_pkg::*;
#(
  parameter int QUEUE_DEPTH = EIS_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  eis_req_if.sink   req,
  eis_rsp_if.source rsp,
  eis_cfg_if.sink   cfg
);

  logic      push;
  logic      can_push;
  logic      pop;
  logic      head_valid;
  eis_item_t push_item;
  eis_item_t head;

  // Classify incoming items and filter out ones with no effect.
  eis_front u_front (
    .req      (req),
    .can_push (can_push),
    .push     (push),
    .item     (push_item)
  );

  // Hold classified items so either side can stall on its own.
  eis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .can_push   (can_push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Advance the sequence and drive results.
  eis_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rsp        (rsp),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

endmodule

FILE: tb/tb_emmc_init_sequencer.sv
// Self-checking testbench for the eMMC init sequencer: directed and random bring-up runs.
`timescale 1ns / 100ps

module tb_emmc_init_sequencer;
  import eis_pkg::*;

  localparam int RANDOM_ITEMS  = 1500;
  localparam int CYCLE_LIMIT   = 800_000;
  // Room for the item queue and result register path plus a full queue of result-less items.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  // Sequencer position as the predictor tracks it.
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_CMD0, SQ_PAUSE0, SQ_CMD1, SQ_PAUSE1, SQ_CMD2, SQ_CMD3,
    SQ_CMD9, SQ_CMD7, SQ_CMD8, SQ_CMD13
  } seq_phase_t;

  // Receiver behavior between hold-offs.
  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        cmd_failed;
    logic [31:0] resp_word;
    logic [8:0]  data_index;
    logic [7:0]  data_byte;
    logic [15:0] tick_us;
  } host_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [2:0]  resp_kind;
    logic        expects_data;
    logic [31:0] remaining_us;
    logic [2:0]  status;
    logic        card_ready;
    logic [31:0] ocr_value;
    logic [31:0] sector_count;
  } bringup_result_t;

  logic clk = 1'b0;
  logic rst;

  eis_req_if req ();
  eis_rsp_if rsp ();
  eis_cfg_if cfg ();

  emmc_init_sequencer u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the sequencer and its budget register.
  // ---------------------------------------------------------------------------
  seq_phase_t  seq_phase;
  logic [31:0] budget_us;
  logic [31:0] elapsed_time_us;
  logic [31:0] ocr_seen;
  logic [7:0]  xcsd_rev;
  logic [2:0]  xcsd_part;
  logic [7:0]  xcsd_bus;
  logic [7:0]  xcsd_timing;
  logic [7:0]  xcsd_sec_size;
  logic [31:0] sectors_seen;
  logic        card_up;
  logic [5:0]  last_cmd_sent;

  bringup_result_t pending_actions[$];
  int items_used;
  int mismatch_count;
  int cycle_count;

  // Sender burst state; fast_send drops the gaps for long tick runs.
  int burst_left;
  bit fast_send;

  // Receiver hold-off: a test posts a length, the ready process counts it down.
  int hold_request;

  function automatic void post_result(logic [1:0] action, logic [31:0] arg, logic [2:0] kind,
                                      logic data, logic [31:0] remain, logic [2:0] status);
    bringup_result_t r;
    r.action       = action;
    r.cmd_index    = last_cmd_sent;
    r.cmd_arg      = arg;
    r.resp_kind    = kind;
    r.expects_data = data;
    r.remaining_us = remain;
    r.status       = status;
    r.card_ready   = card_up;
    r.ocr_value    = ocr_seen;
    r.sector_count = sectors_seen;
    pending_actions.push_back(r);
  endfunction

  function automatic void close_bringup(logic [2:0] status);
    seq_phase = SQ_IDLE;
    post_result(ACT_DONE, '0, RK_NONE, 1'b0, '0, status);
  endfunction

  // The budget is checked before every issue; the command counts as sent anyway.
  function automatic void issue_command(logic [5:0] cmd, logic [31:0] arg, logic [2:0] kind,
                                        logic data, seq_phase_t next);
    last_cmd_sent = cmd;
    if (elapsed_time_us >= budget_us) begin
      close_bringup(ST_TIMEOUT);
    end else begin
      seq_phase = next;
      post_result(ACT_ISSUE, arg, kind, data, budget_us - elapsed_time_us, ST_OK);
    end
  endfunction

  function automatic void clear_card_data();
    elapsed_time_us = '0;
    ocr_seen        = '0;
    xcsd_rev        = '0;
    xcsd_part       = '0;
    xcsd_bus        = '0;
    xcsd_timing     = '0;
    xcsd_sec_size   = '0;
    sectors_seen    = '0;
    card_up         = 1'b0;
    last_cmd_sent   = '0;
  endfunction

  function automatic void store_ext_csd_byte(logic [8:0] idx, logic [7:0] value);
    case (idx)
      XCSD_SEC_SIZE:  xcsd_sec_size = value;
      XCSD_PART_CFG:  xcsd_part = value[2:0];
      XCSD_BUS_WIDTH: xcsd_bus = value;
      XCSD_HS_TIMING: xcsd_timing = value;
      XCSD_REV:       xcsd_rev = value;
      XCSD_SEC_CNT0:  sectors_seen[7:0] = value;
      XCSD_SEC_CNT1:  sectors_seen[15:8] = value;
      XCSD_SEC_CNT2:  sectors_seen[23:16] = value;
      XCSD_SEC_CNT3:  sectors_seen[31:24] = value;
      default: ;
    endcase
  endfunction

  // Response checks run in a fixed order: budget, transport failure, R1 error bits.
  function automatic void take_response(logic failed, logic [31:0] word);
    logic [2:0] kind;
    kind = RK_NONE;
    if (seq_phase inside {SQ_CMD3, SQ_CMD8, SQ_CMD13}) kind = RK_R1;
    if (seq_phase == SQ_CMD7) kind = RK_R1B;
    if (elapsed_time_us >= budget_us) begin
      close_bringup(ST_TIMEOUT);
    end else if (failed) begin
      close_bringup(ST_CMDFAIL);
    end else if ((kind == RK_R1 || kind == RK_R1B) && (word & ~R1_ALLOWED) != '0) begin
      close_bringup(ST_IO);
    end else begin
      case (seq_phase)
        SQ_CMD0: begin
          seq_phase = SQ_PAUSE0;
          post_result(ACT_PAUSE, '0, RK_NONE, 1'b0, '0, ST_OK);
        end
        SQ_CMD1: begin
          ocr_seen = word;
          if ((word & OCR_BUSY_MASK) == '0) begin
            seq_phase = SQ_PAUSE1;
            post_result(ACT_PAUSE, '0, RK_NONE, 1'b0, '0, ST_OK);
          end else if ((word & OCR_MODE_MASK) != OCR_MODE_SECT ||
                       (word & OCR_VOLT_MASK) == '0) begin
            close_bringup(ST_UNSUP);
          end else begin
            issue_command(CMD_ALL_CID, '0, RK_R2, 1'b0, SQ_CMD2);
          end
        end
        SQ_CMD2: issue_command(CMD_SET_RCA, RCA_ARG, RK_R1, 1'b0, SQ_CMD3);
        SQ_CMD3: issue_command(CMD_SEND_CSD, RCA_ARG, RK_R2, 1'b0, SQ_CMD9);
        SQ_CMD9: issue_command(CMD_SELECT, RCA_ARG, RK_R1B, 1'b0, SQ_CMD7);
        SQ_CMD7: issue_command(CMD_EXT_CSD, '0, RK_R1, 1'b1, SQ_CMD8);
        SQ_CMD8: begin
          if (xcsd_rev < XCSD_MIN_REV || xcsd_part != '0 || xcsd_bus != '0 ||
              xcsd_timing != '0 || xcsd_sec_size != '0 || sectors_seen == '0) begin
            close_bringup(ST_UNSUP);
          end else begin
            issue_command(CMD_STATUS, RCA_ARG, RK_R1, 1'b0, SQ_CMD13);
          end
        end
        SQ_CMD13: begin
          if ((word & STATE_MASK) != STATE_TRAN_RDY) begin
            close_bringup(ST_IO);
          end else begin
            card_up = 1'b1;
            close_bringup(ST_OK);
          end
        end
        default: ;
      endcase
    end
  endfunction

  // Apply one accepted item to the predictor; out-of-phase and unknown items are not counted.
  function automatic void advance_bringup(host_item_t it);
    logic [32:0] sum;
    case (it.req_type)
      REQ_START: begin
        items_used++;
        clear_card_data();
        if (budget_us == '0) close_bringup(ST_INVALID);
        else issue_command(CMD_GO_IDLE, '0, RK_NONE, 1'b0, SQ_CMD0);
      end
      REQ_RESP: begin
        if (!(seq_phase inside {SQ_IDLE, SQ_PAUSE0, SQ_PAUSE1})) begin
          items_used++;
          take_response(it.cmd_failed, it.resp_word);
        end
      end
      REQ_DATA: begin
        if (seq_phase == SQ_CMD8) begin
          items_used++;
          store_ext_csd_byte(it.data_index, it.data_byte);
        end
      end
      REQ_TICK: begin
        items_used++;
        sum = {1'b0, elapsed_time_us} + {17'b0, it.tick_us};
        elapsed_time_us = sum[32] ? '1 : sum[31:0];
      end
      REQ_PAUSE: begin
        if (seq_phase inside {SQ_PAUSE0, SQ_PAUSE1}) begin
          items_used++;
          issue_command(CMD_SEND_OP, CMD1_ARG, RK_R3, 1'b0, SQ_CMD1);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every transfer on rsp against the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void show_result(string tag, bringup_result_t r);
    $display("  %s: action=%0d cmd=%0d arg=%h kind=%0d data=%0b remain=%h status=%0d",
             tag, r.action, r.cmd_index, r.cmd_arg, r.resp_kind, r.expects_data,
             r.remaining_us, r.status);
    $display("  %s: ready=%0b ocr=%h sectors=%h", tag, r.card_ready, r.ocr_value,
             r.sector_count);
  endfunction

  always @(posedge clk) begin : check_results
    bringup_result_t got;
    bringup_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.action       = rsp.action;
      got.cmd_index    = rsp.cmd_index;
      got.cmd_arg      = rsp.cmd_arg;
      got.resp_kind    = rsp.resp_kind;
      got.expects_data = rsp.expects_data;
      got.remaining_us = rsp.remaining_us;
      got.status       = rsp.status;
      got.card_ready   = rsp.card_ready;
      got.ocr_value    = rsp.ocr_value;
      got.sector_count = rsp.sector_count;
      if (pending_actions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] result with nothing predicted", $realtime);
          show_result("actual", got);
        end
      end else begin
        want = pending_actions.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] result mismatch", $realtime);
            show_result("expected", want);
            show_result("actual", got);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: hold-offs on request, otherwise streaming, random or patterned stalls.
  // ---------------------------------------------------------------------------
  initial begin : rsp_ready_driver
    int       hold_left;
    int       mode_left;
    rx_mode_t rx_mode;
    logic [7:0] stall_pattern;
    hold_left     = 0;
    mode_left     = 0;
    rx_mode       = RX_STREAM;
    stall_pattern = 8'b1011_0110;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 2))
            0: rx_mode = RX_STREAM;
            1: rx_mode = RX_RANDOM;
            default: rx_mode = RX_PATTERN;
          endcase
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
          RX_STREAM: rsp.ready <= 1'b1;
          RX_RANDOM: rsp.ready <= 1'($urandom_range(0, 1));
          default: begin
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            rsp.ready <= stall_pattern[0];
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until transfer; gaps fall between random bursts.
  task automatic send_item(input logic [2:0] kind, input logic failed, input logic [31:0] word,
                           input logic [8:0] idx, input logic [7:0] value,
                           input logic [15:0] tick);
    host_item_t it;
    int         gap;
    it = '{req_type: kind, cmd_failed: failed, resp_word: word, data_index: idx,
           data_byte: value, tick_us: tick};
    if (!fast_send && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    req.valid      <= 1'b1;
    req.req_type   <= it.req_type;
    req.cmd_failed <= it.cmd_failed;
    req.resp_word  <= it.resp_word;
    req.data_index <= it.data_index;
    req.data_byte  <= it.data_byte;
    req.tick_us    <= it.tick_us;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    advance_bringup(it);
  endtask

  task automatic send_start();
    send_item(REQ_START, 1'b0, '0, '0, '0, '0);
  endtask

  task automatic send_pause_done();
    send_item(REQ_PAUSE, 1'b0, '0, '0, '0, '0);
  endtask

  task automatic send_resp(input logic failed, input logic [31:0] word);
    send_item(REQ_RESP, failed, word, '0, '0, '0);
  endtask

  task automatic send_data(input logic [8:0] idx, input logic [7:0] value);
    send_item(REQ_DATA, 1'b0, '0, idx, value, '0);
  endtask

  task automatic send_tick(input logic [15:0] tick);
    send_item(REQ_TICK, 1'b0, '0, '0, '0, tick);
  endtask

  // Drop valid, wait for every predicted result, then let the item queue run dry.
  task automatic settle_after_results();
    req.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_budget(input logic [31:0] value);
    settle_after_results();
    cfg.valid             <= 1'b1;
    cfg.timeout_budget_us <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    budget_us = value;
  endtask

  // ---------------------------------------------------------------------------
  // Random content generators.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_budget();
    case ($urandom_range(0, 19))
      0:       return '1;
      1:       return '0;
      2, 3:    return $urandom;
      4, 5, 6, 7, 8, 9, 10, 11: return $urandom_range(1, 3000);
      default: return $urandom_range(3000, 500000);
    endcase
  endfunction

  function automatic logic [15:0] pick_tick();
    if ($urandom_range(0, 99) < 15) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 200));
  endfunction

  function automatic logic pick_failure();
    return $urandom_range(0, 99) < 3;
  endfunction

  // Mostly clean card status; now and then any bit, which usually trips the R1 check.
  function automatic logic [31:0] pick_r1_word();
    if ($urandom_range(0, 99) < 6) return $urandom;
    return $urandom & R1_ALLOWED;
  endfunction

  function automatic logic [31:0] pick_status_word();
    if ($urandom_range(0, 99) < 10) return $urandom & R1_ALLOWED;
    return ($urandom & R1_ALLOWED & ~STATE_MASK) | STATE_TRAN_RDY;
  endfunction

  // Busy OCR keeps CMD1 polling; a ready OCR is mostly sector mode with some voltage.
  function automatic logic [31:0] pick_ocr_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom & ~OCR_BUSY_MASK;
    if (roll < 90)
      return ($urandom & ~OCR_MODE_MASK) | OCR_BUSY_MASK | OCR_MODE_SECT |
             (32'h1 << $urandom_range(15, 23));
    return $urandom | OCR_BUSY_MASK;
  endfunction

  // Send the EXT_CSD fields that matter in random order, mixed with stray bytes.
  // One field in seven-ish blocks is spoiled so the device is rejected.
  task automatic stream_ext_csd();
    logic [8:0] idx_q[$];
    logic [7:0] val_q[$];
    logic [7:0] sec_bytes[4];
    int         flaw;
    int         pick;
    flaw = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 6) : 0;
    foreach (sec_bytes[i]) sec_bytes[i] = (flaw == 6) ? 8'h00 : 8'($urandom);
    if (flaw != 6 && sec_bytes[0] == 8'h00) sec_bytes[0] = 8'h01;
    idx_q.push_back(XCSD_SEC_SIZE);
    val_q.push_back((flaw == 1) ? 8'($urandom_range(1, 255)) : 8'h00);
    idx_q.push_back(XCSD_PART_CFG);
    val_q.push_back((flaw == 2) ? (8'($urandom) | 8'h01) : (8'($urandom) & 8'hf8));
    idx_q.push_back(XCSD_BUS_WIDTH);
    val_q.push_back((flaw == 3) ? 8'($urandom_range(1, 255)) : 8'h00);
    idx_q.push_back(XCSD_HS_TIMING);
    val_q.push_back((flaw == 4) ? 8'($urandom_range(1, 255)) : 8'h00);
    idx_q.push_back(XCSD_REV);
    val_q.push_back((flaw == 5) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255)));
    idx_q.push_back(XCSD_SEC_CNT0);
    val_q.push_back(sec_bytes[0]);
    idx_q.push_back(XCSD_SEC_CNT1);
    val_q.push_back(sec_bytes[1]);
    idx_q.push_back(XCSD_SEC_CNT2);
    val_q.push_back(sec_bytes[2]);
    idx_q.push_back(XCSD_SEC_CNT3);
    val_q.push_back(sec_bytes[3]);
    repeat ($urandom_range(0, 4)) begin
      idx_q.push_back(9'($urandom));
      val_q.push_back(8'($urandom));
    end
    while (idx_q.size() > 0) begin
      pick = $urandom_range(0, idx_q.size() - 1);
      send_data(idx_q[pick], val_q[pick]);
      idx_q.delete(pick);
      val_q.delete(pick);
      if ($urandom_range(0, 99) < 8) send_tick(pick_tick());
    end
  endtask

  // Any request type, including the unused codes, with every field random.
  task automatic send_noise();
    send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom, 9'($urandom),
              8'($urandom), 16'($urandom));
  endtask

  // One bring-up attempt: answer whatever the sequencer asked for, with ticks and
  // noise sprinkled in, until it finishes or the step budget runs out.
  task automatic run_bringup_attempt();
    int steps;
    int roll;
    bit streamed;
    steps    = 0;
    streamed = 1'b0;
    send_start();
    while (seq_phase != SQ_IDLE && steps < 60) begin
      steps++;
      if (seq_phase != SQ_CMD8) streamed = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_tick(pick_tick());
      end else if (roll < 12) begin
        send_noise();
      end else begin
        case (seq_phase)
          SQ_PAUSE0, SQ_PAUSE1: send_pause_done();
          SQ_CMD1:              send_resp(pick_failure(), pick_ocr_word());
          SQ_CMD3, SQ_CMD7:     send_resp(pick_failure(), pick_r1_word());
          SQ_CMD13:             send_resp(pick_failure(), pick_status_word());
          SQ_CMD8: begin
            if (!streamed) begin
              stream_ext_csd();
              streamed = 1'b1;
            end else begin
              send_resp(pick_failure(), pick_r1_word());
            end
          end
          default: send_resp(pick_failure(), $urandom);
        endcase
      end
    end
    // Stray traffic after the finish must be ignored.
    if ($urandom_range(0, 3) == 0) send_noise();
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Before any start, and with the reset budget of zero.
  task automatic test_zero_budget();
    send_resp(1'b0, STATE_TRAN_RDY);
    send_data(XCSD_REV, 8'h08);
    send_pause_done();
    send_tick(16'h0000);
    send_start();
    send_resp(1'b1, '0);
  endtask

  // A full, successful bring-up with one busy OCR poll.
  task automatic test_clean_bringup();
    write_budget(32'd1_000_000);
    send_start();
    send_pause_done();              // not expected while CMD0 is out
    send_resp(1'b0, 32'h0000_0000);
    send_pause_done();
    send_resp(1'b0, 32'h00ff_8000); // still busy
    send_pause_done();
    send_resp(1'b0, 32'hc0ff_8080);
    send_resp(1'b0, 32'hffff_ffff); // CID: R2, not checked
    send_resp(1'b0, 32'h0000_0500);
    send_resp(1'b0, 32'h0000_0000);
    send_resp(1'b0, R1_ALLOWED);
    send_data(XCSD_REV, 8'hff);
    send_data(XCSD_PART_CFG, 8'hf8);
    send_data(9'd511, 8'hff);
    send_data(XCSD_SEC_CNT0, 8'h00);
    send_tick(16'd37);
    send_data(XCSD_SEC_CNT2, 8'he9);
    send_data(XCSD_SEC_CNT3, 8'h80);
    send_resp(1'b0, 32'h0000_0000);
    send_resp(1'b0, STATE_TRAN_RDY);
  endtask

  // Budget exhausted at a response, before an issue, and the smallest budget.
  task automatic test_timeouts();
    write_budget(32'd10);
    send_start();
    send_tick(16'd10);
    send_resp(1'b0, $urandom);
    send_start();
    send_resp(1'b0, $urandom);
    send_tick(16'hffff);
    send_pause_done();
    write_budget(32'd1);
    send_start();
    send_resp(1'b1, $urandom);
  endtask

  // Run elapsed time past a large budget with back-to-back maximum ticks.
  task automatic test_back_to_back_ticks();
    write_budget(32'h00a0_0000);
    send_start();
    fast_send = 1'b1;
    repeat (200) send_tick(16'hffff);
    fast_send = 1'b0;
    send_resp(1'b0, '0);
    send_start();
  endtask

  // Random bring-ups over changing budgets; some attempts run into a long
  // receiver hold-off so the item queue fills and req.ready drops.
  task automatic test_random_bringup();
    int base;
    int attempts;
    base     = items_used;
    attempts = 0;
    while (items_used - base < RANDOM_ITEMS) begin
      if (attempts == 0 || $urandom_range(0, 3) == 0) write_budget(pick_budget());
      if (attempts % 25 == 3) hold_request = $urandom_range(150, 300);
      run_bringup_attempt();
      attempts++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    seq_phase      = SQ_IDLE;
    budget_us      = '0;
    clear_card_data();
    items_used     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 0;
    fast_send      = 1'b0;
    hold_request   = 0;

    rst                   <= 1'b1;
    req.valid             <= 1'b0;
    req.req_type          <= REQ_START;
    req.cmd_failed        <= 1'b0;
    req.resp_word         <= '0;
    req.data_index        <= '0;
    req.data_byte         <= '0;
    req.tick_us           <= '0;
    cfg.valid             <= 1'b0;
    cfg.timeout_budget_us <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_budget();
    test_clean_bringup();
    test_timeouts();
    test_back_to_back_ticks();
    test_random_bringup();

    settle_after_results();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
